FILE: rtl/btlca_pkg.sv
package btlca_pkg;

   localparam int POS_W = 13;
   localparam int CMD_W = 2;

   localparam int DEF_MAX_NODES   = 2048;
   localparam int DEF_LIFT_LEVELS = 11;

   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   localparam logic SYM_OPEN  = 1'b0;
   localparam logic SYM_CLOSE = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

endpackage

FILE: rtl/btlca_ram.sv
module btlca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/bracket_tree_lca_engine_core.sv
// Bracket-sequence tree with lowest-common-ancestor queries. Load symbols one
// per transfer (0 opens a node, 1 closes the top node), begin a new tree with
// the begin command, and query two sequence positions to get the open and close
// positions of their lowest common ancestor. Per-node and per-position state sits
// in synchronous RAMs with one read and one write port; one item is worked at a
// time and req_stall is high while it runs. An open does one ancestor-table read
// and one write per lifting level, and a query climbs to equal depth and then
// descends jointly, both paced by the one read port of the ancestor RAM. A query
// with a position outside the loaded sequence answers with status bad and zero
// positions, without walking the tree.
module bracket_tree_lca_engine_core
   import btlca_pkg::*;
#(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CMD_W-1:0] req_command,
   input  logic             req_symbol,
   input  logic [POS_W-1:0] req_first_pos,
   input  logic [POS_W-1:0] req_second_pos,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [POS_W-1:0] rsp_open_pos,
   output logic [POS_W-1:0] rsp_close_pos,
   output logic             rsp_status
);

   localparam int NW  = $clog2(MAX_NODES + 1);
   localparam int AW  = $clog2(MAX_NODES);
   localparam int PW  = $clog2(2 * MAX_NODES + 1);
   localparam int PAW = AW + 1;
   localparam int KW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int DW  = (NW > LIFT_LEVELS) ? NW : LIFT_LEVELS;
   localparam int CW  = (PW > POS_W) ? PW : POS_W;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_OPEN  = 5'd1;
   localparam logic [4:0] S_ODEP  = 5'd2;
   localparam logic [4:0] S_LRD   = 5'd3;
   localparam logic [4:0] S_LWR   = 5'd4;
   localparam logic [4:0] S_CLOSE = 5'd5;
   localparam logic [4:0] S_Q1    = 5'd6;
   localparam logic [4:0] S_Q2    = 5'd7;
   localparam logic [4:0] S_Q3    = 5'd8;
   localparam logic [4:0] S_Q4    = 5'd9;
   localparam logic [4:0] S_QURD  = 5'd10;
   localparam logic [4:0] S_QUWR  = 5'd11;
   localparam logic [4:0] S_QDRA  = 5'd12;
   localparam logic [4:0] S_QDRB  = 5'd13;
   localparam logic [4:0] S_QDCMP = 5'd14;
   localparam logic [4:0] S_QFRD  = 5'd15;
   localparam logic [4:0] S_QFWR  = 5'd16;
   localparam logic [4:0] S_QRRD  = 5'd17;
   localparam logic [4:0] S_QRCAP = 5'd18;
   localparam logic [4:0] S_EMIT  = 5'd19;

   localparam logic [KW-1:0] K_LAST = KW'(LIFT_LEVELS - 1);

   logic [4:0]       state_ff, state_in;
   logic [NW-1:0]    sp_ff, sp_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [NW-1:0]    ncnt_ff, ncnt_in;
   logic [NW-1:0]    a_ff, a_in;
   logic [NW-1:0]    b_ff, b_in;
   logic [NW-1:0]    ra_ff, ra_in;
   logic [NW-1:0]    nid_ff, nid_in;
   logic [NW-1:0]    da_ff, da_in;
   logic [DW-1:0]    diff_ff, diff_in;
   logic [KW-1:0]    k_ff, k_in;
   logic             take_ff, take_in;
   logic [POS_W-1:0] p2_ff, p2_in;
   logic [POS_W-1:0] res_open_ff, res_open_in;
   logic [POS_W-1:0] res_close_ff, res_close_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_open_ff, rsp_open_in;
   logic [POS_W-1:0] rsp_close_ff, rsp_close_in;
   logic             rsp_status_ff, rsp_status_in;

   logic              stk_we;
   logic [AW-1:0]     stk_wa, stk_ra;
   logic [NW-1:0]     stk_wd, stk_rd;
   logic              npos_we;
   logic [PAW-1:0]    npos_wa, npos_ra;
   logic [NW-1:0]     npos_wd, npos_rd;
   logic              opos_we;
   logic [AW-1:0]     opos_wa, node_ra;
   logic [PW-1:0]     opos_wd, opos_rd;
   logic              cpos_we;
   logic [AW-1:0]     cpos_wa;
   logic [PW-1:0]     cpos_wd, cpos_rd;
   logic              dep_we;
   logic [AW-1:0]     dep_wa, dep_ra;
   logic [NW-1:0]     dep_wd, dep_rd;
   logic              anc_we;
   logic [AW+KW-1:0]  anc_wa, anc_ra;
   logic [NW-1:0]     anc_wd, anc_rd;

   logic             accept;
   logic             out_free;
   logic             bad_query;
   logic [CW-1:0]    p1_ext, p2_ext, pos_ext;
   logic [NW-1:0]    parent;
   logic [NW-1:0]    anc_val_a, anc_val_b;
   logic [DW-1:0]    pow_k;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign p1_ext  = CW'(req_first_pos);
   assign p2_ext  = CW'(req_second_pos);
   assign pos_ext = CW'(pos_ff);
   assign bad_query = (p1_ext == '0) || (p2_ext == '0) || (p1_ext > pos_ext) ||
                      (p2_ext > pos_ext);

   assign parent    = (sp_ff == '0) ? '0 : stk_rd;
   assign anc_val_a = (a_ff == '0) ? '0 : anc_rd;
   assign anc_val_b = (b_ff == '0) ? '0 : anc_rd;
   assign pow_k     = DW'(1) << k_ff;

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      pos_in        = pos_ff;
      ncnt_in       = ncnt_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      ra_in         = ra_ff;
      nid_in        = nid_ff;
      da_in         = da_ff;
      diff_in       = diff_ff;
      k_in          = k_ff;
      take_in       = take_ff;
      p2_in         = p2_ff;
      res_open_in   = res_open_ff;
      res_close_in  = res_close_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_open_in   = rsp_open_ff;
      rsp_close_in  = rsp_close_ff;
      rsp_status_in = rsp_status_ff;

      stk_we  = 1'b0;
      stk_wa  = AW'(sp_ff);
      stk_wd  = NW'(ncnt_ff + NW'(1));
      stk_ra  = AW'(sp_ff - NW'(1));
      npos_we = 1'b0;
      npos_wa = PAW'(pos_ff);
      npos_wd = '0;
      npos_ra = PAW'(req_first_pos - POS_W'(1));
      opos_we = 1'b0;
      opos_wa = AW'(ncnt_ff);
      opos_wd = PW'(pos_ff + PW'(1));
      cpos_we = 1'b0;
      cpos_wa = AW'(ncnt_ff);
      cpos_wd = '0;
      node_ra = AW'(a_ff - NW'(1));
      dep_we  = 1'b0;
      dep_wa  = AW'(nid_ff - NW'(1));
      dep_wd  = '0;
      dep_ra  = AW'(a_ff - NW'(1));
      anc_we  = 1'b0;
      anc_wa  = {AW'(nid_ff - NW'(1)), k_ff};
      anc_wd  = '0;
      anc_ra  = {AW'(a_ff - NW'(1)), k_ff};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_BEGIN: begin
                     sp_in   = '0;
                     pos_in  = '0;
                     ncnt_in = '0;
                  end
                  CMD_LOAD: begin
                     if (req_symbol == SYM_OPEN) begin
                        if (ncnt_ff < NW'(MAX_NODES)) begin
                           state_in = S_OPEN;
                        end
                     end else if (sp_ff != '0) begin
                        state_in = S_CLOSE;
                     end
                  end
                  CMD_QUERY: begin
                     p2_in = req_second_pos;
                     if (bad_query) begin
                        res_open_in   = '0;
                        res_close_in  = '0;
                        res_status_in = STATUS_BAD;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_Q1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_OPEN: begin
            // stack read issued at accept gives the parent
            stk_we  = 1'b1;
            npos_we = 1'b1;
            npos_wd = NW'(ncnt_ff + NW'(1));
            opos_we = 1'b1;
            cpos_we = 1'b1;
            anc_we  = 1'b1;
            anc_wa  = {AW'(ncnt_ff), KW'(0)};
            anc_wd  = parent;
            dep_ra  = AW'(parent - NW'(1));
            nid_in  = NW'(ncnt_ff + NW'(1));
            ncnt_in = NW'(ncnt_ff + NW'(1));
            sp_in   = NW'(sp_ff + NW'(1));
            pos_in  = PW'(pos_ff + PW'(1));
            a_in    = parent;
            state_in = S_ODEP;
         end
         S_ODEP: begin
            dep_we = 1'b1;
            dep_wd = NW'(((a_ff == '0) ? '0 : dep_rd) + NW'(1));
            anc_ra = {AW'(a_ff - NW'(1)), KW'(0)};
            if (LIFT_LEVELS == 1) begin
               state_in = S_IDLE;
            end else begin
               k_in     = KW'(1);
               state_in = S_LWR;
            end
         end
         S_LRD: begin
            anc_ra   = {AW'(a_ff - NW'(1)), KW'(k_ff - KW'(1))};
            state_in = S_LWR;
         end
         S_LWR: begin
            anc_we = 1'b1;
            anc_wd = anc_val_a;
            a_in   = anc_val_a;
            if (k_ff == K_LAST) begin
               state_in = S_IDLE;
            end else begin
               k_in     = KW'(k_ff + KW'(1));
               state_in = S_LRD;
            end
         end
         S_CLOSE: begin
            stk_we  = 1'b0;
            npos_we = 1'b1;
            npos_wd = stk_rd;
            cpos_we = 1'b1;
            cpos_wa = AW'(stk_rd - NW'(1));
            cpos_wd = PW'(pos_ff + PW'(1));
            sp_in   = NW'(sp_ff - NW'(1));
            pos_in  = PW'(pos_ff + PW'(1));
            state_in = S_IDLE;
         end
         S_Q1: begin
            a_in     = npos_rd;
            npos_ra  = PAW'(p2_ff - POS_W'(1));
            state_in = S_Q2;
         end
         S_Q2: begin
            b_in     = npos_rd;
            state_in = S_Q3;
         end
         S_Q3: begin
            da_in    = dep_rd;
            dep_ra   = AW'(b_ff - NW'(1));
            state_in = S_Q4;
         end
         S_Q4: begin
            // keep the deeper node in a
            if (da_ff < dep_rd) begin
               a_in    = b_ff;
               b_in    = a_ff;
               diff_in = DW'(dep_rd - da_ff);
            end else begin
               diff_in = DW'(da_ff - dep_rd);
            end
            k_in     = K_LAST;
            state_in = S_QURD;
         end
         S_QURD: begin
            take_in = (diff_ff >= pow_k);
            if (diff_ff >= pow_k) begin
               diff_in = diff_ff - pow_k;
            end
            state_in = S_QUWR;
         end
         S_QUWR: begin
            if (take_ff) begin
               a_in = anc_val_a;
            end
            if (k_ff == '0) begin
               k_in = K_LAST;
               if ((take_ff ? anc_val_a : a_ff) == b_ff) begin
                  state_in = S_QRRD;
               end else begin
                  state_in = S_QDRA;
               end
            end else begin
               k_in     = KW'(k_ff - KW'(1));
               state_in = S_QURD;
            end
         end
         S_QDRA: begin
            state_in = S_QDRB;
         end
         S_QDRB: begin
            ra_in    = anc_val_a;
            anc_ra   = {AW'(b_ff - NW'(1)), k_ff};
            state_in = S_QDCMP;
         end
         S_QDCMP: begin
            if (ra_ff != anc_val_b) begin
               a_in = ra_ff;
               b_in = anc_val_b;
            end
            if (k_ff == '0) begin
               state_in = S_QFRD;
            end else begin
               k_in     = KW'(k_ff - KW'(1));
               state_in = S_QDRA;
            end
         end
         S_QFRD: begin
            anc_ra   = {AW'(a_ff - NW'(1)), KW'(0)};
            state_in = S_QFWR;
         end
         S_QFWR: begin
            a_in     = anc_val_a;
            state_in = S_QRRD;
         end
         S_QRRD: begin
            state_in = S_QRCAP;
         end
         S_QRCAP: begin
            res_open_in   = (a_ff == '0) ? '0 : POS_W'(opos_rd);
            res_close_in  = (a_ff == '0) ? '0 : POS_W'(cpos_rd);
            res_status_in = STATUS_OK;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_open_in   = res_open_ff;
               rsp_close_in  = res_close_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         pos_ff       <= '0;
         ncnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         pos_ff       <= pos_in;
         ncnt_ff      <= ncnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      ra_ff         <= ra_in;
      nid_ff        <= nid_in;
      da_ff         <= da_in;
      diff_ff       <= diff_in;
      k_ff          <= k_in;
      take_ff       <= take_in;
      p2_ff         <= p2_in;
      res_open_ff   <= res_open_in;
      res_close_ff  <= res_close_in;
      res_status_ff <= res_status_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_close_ff  <= rsp_close_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_open_pos  = rsp_open_ff;
   assign rsp_close_pos = rsp_close_ff;
   assign rsp_status    = rsp_status_ff;

   btlca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   btlca_ram #(.WIDTH(NW), .DEPTH(2 * MAX_NODES)) u_node_at_pos (
      .clock   (clock),
      .wr_en   (npos_we),
      .wr_addr (npos_wa),
      .wr_data (npos_wd),
      .rd_addr (npos_ra),
      .rd_data (npos_rd)
   );

   btlca_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_open_pos (
      .clock   (clock),
      .wr_en   (opos_we),
      .wr_addr (opos_wa),
      .wr_data (opos_wd),
      .rd_addr (node_ra),
      .rd_data (opos_rd)
   );

   btlca_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_close_pos (
      .clock   (clock),
      .wr_en   (cpos_we),
      .wr_addr (cpos_wa),
      .wr_data (cpos_wd),
      .rd_addr (node_ra),
      .rd_data (cpos_rd)
   );

   btlca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_depth (
      .clock   (clock),
      .wr_en   (dep_we),
      .wr_addr (dep_wa),
      .wr_data (dep_wd),
      .rd_addr (dep_ra),
      .rd_data (dep_rd)
   );

   btlca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES * (2 ** KW))) u_ancestor (
      .clock   (clock),
      .wr_en   (anc_we),
      .wr_addr (anc_wa),
      .wr_data (anc_wd),
      .rd_addr (anc_ra),
      .rd_data (anc_rd)
   );

   a_stack_bounded: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= ncnt_ff)
      else $error("open stack deeper than node count");

   a_nodes_bounded: assert property (@(posedge clock) disable iff (reset)
      ncnt_ff <= NW'(MAX_NODES))
      else $error("node count beyond capacity");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      (PW + 1)'(pos_ff) <= (PW + 1)'({ncnt_ff, 1'b0}))
      else $error("position count beyond twice the node count");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside emit step");

endmodule
